// ===== hw/rtl/wvb_pkg.sv =====
// Shared types and constants of the window vote binarise filter.
`default_nettype none

package wvb_pkg;

    // Field and register widths.
    localparam int PIX_W      = 8;
    localparam int FW_W       = 11;
    localparam int FH_W       = 11;
    localparam int KS_W       = 3;
    localparam int ROW_W      = 10;
    localparam int COL_OUT_W  = 10;
    localparam int APB_AW     = 4;
    localparam int APB_DW     = 32;

    // Frame height limit and the vote factor of the threshold.
    localparam int MAX_HEIGHT  = 1024;
    localparam int VOTE_FACTOR = 5;

    // The kernel size register holds three bits, so a window never exceeds 7 by 7.
    localparam int KS_LIMIT   = 7;
    localparam int COL_SUM_W  = 11;
    localparam int WIN_SUM_W  = 14;
    localparam int THR_W      = 11;

    // Register map, one 32-bit word per register.
    typedef enum logic [1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_KERNEL_SIZE  = 2'd2,
        REG_FG_VALUE     = 2'd3
    } wvb_reg_idx_t;

    // Result information that travels down the pipeline with each pixel.
    typedef struct packed {
        logic                 emit;
        logic [ROW_W-1:0]     center_row;
        logic [COL_OUT_W-1:0] center_col;
        logic                 frame_end;
    } wvb_tag_t;

endpackage

`default_nettype wire

// ===== hw/rtl/window_vote_binarize_filter.sv =====
// Top level of the window vote binarise filter: registers, line memory, cells and pipeline.
//
// Pixels arrive on the s_ channel in raster order, one request per pixel,
// from the start of a frame. For every position whose k-by-k window lies
// wholly inside the frame, a result request leaves on the m_ channel once
// the bottom-right pixel of that window has been taken: the foreground
// level if the window sum reaches five times that level, otherwise 0,
// with the window centre and a flag on the last result of the frame.
// Border positions produce nothing. The APB port sets frame size, kernel
// size and foreground level; write it only while the block is idle.
// Throughput is one pixel per cycle while the m_ready side keeps up. A
// result passes the line memory read, the window cells, the window sum
// register and the output register in turn after its pixel is taken.
// The four stages drain into any free slot, so input is still taken while
// a result waits; s_ready falls only when all four stages hold a request.
// Reset restores the register defaults and the frame position to the
// first pixel. The line memory is not cleared and needs no start-up time.
`default_nettype none

module window_vote_binarize_filter import wvb_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_KERNEL = 7
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // Configuration port
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_AW-1:0]     paddr,
    input  wire logic [APB_DW-1:0]     pwdata,
    output logic      [APB_DW-1:0]     prdata,
    output logic                       pready,
    // Pixel input
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [PIX_W-1:0]      s_pixel_in,
    // Result output
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic      [PIX_W-1:0]      m_pixel_out,
    output logic      [ROW_W-1:0]      m_center_row,
    output logic      [COL_OUT_W-1:0]  m_center_col,
    output logic                       m_frame_end
);

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int EW   = (CW + 1 > FW_W) ? CW + 1 : FW_W;
    localparam int SW   = $clog2(MAX_KERNEL);
    localparam int KMAX = (MAX_KERNEL - 1) | 1;
    localparam int NK   = (KMAX < KS_LIMIT) ? KMAX : KS_LIMIT;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [FW_W-1:0]  fw_reg, fw_next;
    logic [FH_W-1:0]  fh_reg, fh_next;
    logic [KS_W-1:0]  ks_reg, ks_next;
    logic [PIX_W-1:0] fg_reg, fg_next;
    logic             cfg_write;
    wvb_reg_idx_t     cfg_idx;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = wvb_reg_idx_t'(paddr[3:2]);

    // Decode a write into the addressed register.
    always_comb begin
        fw_next = fw_reg;
        fh_next = fh_reg;
        ks_next = ks_reg;
        fg_next = fg_reg;
        if (cfg_write) begin
            unique case (cfg_idx)
                REG_FRAME_WIDTH:  fw_next = pwdata[FW_W-1:0];
                REG_FRAME_HEIGHT: fh_next = pwdata[FH_W-1:0];
                REG_KERNEL_SIZE:  ks_next = pwdata[KS_W-1:0];
                REG_FG_VALUE:     fg_next = pwdata[PIX_W-1:0];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fw_reg <= FW_W'(960);
            fh_reg <= FH_W'(540);
            ks_reg <= KS_W'(3);
            fg_reg <= PIX_W'(255);
        end else begin
            fw_reg <= fw_next;
            fh_reg <= fh_next;
            ks_reg <= ks_next;
            fg_reg <= fg_next;
        end
    end

    // Register read back.
    always_comb begin
        unique case (cfg_idx)
            REG_FRAME_WIDTH:  prdata = APB_DW'(fw_reg);
            REG_FRAME_HEIGHT: prdata = APB_DW'(fh_reg);
            REG_KERNEL_SIZE:  prdata = APB_DW'(ks_reg);
            REG_FG_VALUE:     prdata = APB_DW'(fg_reg);
        endcase
    end

    // ------------------------------------------------------------------
    // Effective frame and kernel sizes
    // ------------------------------------------------------------------
    logic [EW-1:0]   eff_w;
    logic [FH_W-1:0] eff_h;
    logic [KS_W-1:0] eff_k;
    logic [KS_W-1:0] k_odd;
    logic [KS_W-1:0] two_rad;
    logic [KS_W-1:0] rad;

    // A zero size counts as one and an oversize value is clamped.
    always_comb begin
        if (fw_reg == '0) begin
            eff_w = EW'(1);
        end else if (EW'(fw_reg) > EW'(MAX_WIDTH)) begin
            eff_w = EW'(MAX_WIDTH);
        end else begin
            eff_w = EW'(fw_reg);
        end

        if (fh_reg == '0) begin
            eff_h = FH_W'(1);
        end else if (fh_reg > FH_W'(MAX_HEIGHT)) begin
            eff_h = FH_W'(MAX_HEIGHT);
        end else begin
            eff_h = fh_reg;
        end

        k_odd = ks_reg | KS_W'(1);
        eff_k = (k_odd > KS_W'(NK)) ? KS_W'(NK) : k_odd;
    end

    // The kernel is odd, so twice the radius is one less than its side.
    assign two_rad = eff_k - KS_W'(1);
    assign rad     = eff_k >> 1;

    // ------------------------------------------------------------------
    // Pipeline handshake
    // ------------------------------------------------------------------
    logic va_reg, va_next;
    logic vb_reg, vb_next;
    logic vc_reg, vc_next;
    logic m_valid_reg, m_valid_next;
    logic adv_a, adv_b, adv_c;
    logic out_free;
    logic accept;

    wvb_tag_t tag_in, tag_a_reg, tag_b_reg, tag_c_reg;

    // Each stage moves on when the next one is empty or moving too.
    assign out_free = !m_valid_reg || m_ready;
    assign adv_c    = vc_reg && (!tag_c_reg.emit || out_free);
    assign adv_b    = vb_reg && (!vc_reg || adv_c);
    assign adv_a    = va_reg && (!vb_reg || adv_b);
    assign s_ready  = !va_reg || adv_a;
    assign accept   = s_valid && s_ready;

    always_comb begin
        va_next      = accept || (va_reg && !adv_a);
        vb_next      = adv_a || (vb_reg && !adv_b);
        vc_next      = adv_b || (vc_reg && !adv_c);
        m_valid_next = (adv_c && tag_c_reg.emit) || (m_valid_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg      <= 1'b0;
            vb_reg      <= 1'b0;
            vc_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            va_reg      <= va_next;
            vb_reg      <= vb_next;
            vc_reg      <= vc_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // Frame position counters
    // ------------------------------------------------------------------
    logic [CW-1:0]    col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [SW-1:0]    slot_reg, slot_next;
    logic [EW-1:0]    col_inc;
    logic [FH_W-1:0]  row_inc;

    assign col_inc = EW'(col_reg) + EW'(1);
    assign row_inc = FH_W'(row_reg) + FH_W'(1);

    // The slot names the line memory bank of the current row: row modulo MAX_KERNEL.
    always_comb begin
        col_next  = col_reg;
        row_next  = row_reg;
        slot_next = slot_reg;
        if (accept) begin
            if (col_inc >= eff_w) begin
                col_next = '0;
                if (row_inc >= eff_h) begin
                    row_next  = '0;
                    slot_next = '0;
                end else begin
                    row_next  = row_inc[ROW_W-1:0];
                    slot_next = (slot_reg == SW'(MAX_KERNEL - 1)) ? '0 : slot_reg + SW'(1);
                end
            end else begin
                col_next = col_inc[CW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            row_reg  <= '0;
            slot_reg <= '0;
        end else begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            slot_reg <= slot_next;
        end
    end

    // Decide at entry whether this pixel completes an interior window.
    always_comb begin
        tag_in.emit = (EW'(col_reg) < eff_w) && (FH_W'(row_reg) < eff_h)
                   && (row_reg >= ROW_W'(two_rad)) && (col_reg >= CW'(two_rad));
        tag_in.center_row = row_reg - ROW_W'(rad);
        tag_in.center_col = COL_OUT_W'(col_reg - CW'(rad));
        tag_in.frame_end  = (EW'(col_reg) == eff_w - EW'(1))
                         && (FH_W'(row_reg) == eff_h - FH_W'(1));
    end

    // ------------------------------------------------------------------
    // Line memory: one bank per row slot, all read at the current column
    // ------------------------------------------------------------------
    logic [PIX_W-1:0] rd_data [MAX_KERNEL];

    for (genvar b = 0; b < MAX_KERNEL; b++) begin : g_bank
        wvb_ram #(
            .WIDTH (PIX_W),
            .DEPTH (MAX_WIDTH)
        ) u_bank (
            .aclk  (aclk),
            .we    (accept && (slot_reg == SW'(b))),
            .waddr (col_reg),
            .wdata (s_pixel_in),
            .re    (accept),
            .raddr (col_reg),
            .rdata (rd_data[b])
        );
    end

    // ------------------------------------------------------------------
    // Stage A: pixel with the column above it, summed over the kernel rows
    // ------------------------------------------------------------------
    logic [PIX_W-1:0]     pix_a_reg;
    logic [SW-1:0]        slot_a_reg;
    logic [PIX_W-1:0]     colv [NK];
    logic [SW:0]          bank_idx [NK];
    logic [COL_SUM_W-1:0] col_sum;

    always_ff @(posedge aclk) begin
        if (accept) begin
            pix_a_reg  <= s_pixel_in;
            slot_a_reg <= slot_reg;
            tag_a_reg  <= tag_in;
        end
    end

    // Rotate the banks so that entry dr holds the row dr above the current one.
    always_comb begin
        bank_idx[0] = '0;
        colv[0]     = pix_a_reg;
        for (int dr = 1; dr < NK; dr++) begin
            if ({1'b0, slot_a_reg} >= (SW+1)'(dr)) begin
                bank_idx[dr] = {1'b0, slot_a_reg} - (SW+1)'(dr);
            end else begin
                bank_idx[dr] = {1'b0, slot_a_reg} + (SW+1)'(MAX_KERNEL - dr);
            end
            colv[dr] = rd_data[bank_idx[dr][SW-1:0]];
        end
    end

    always_comb begin
        col_sum = '0;
        for (int dr = 0; dr < NK; dr++) begin
            if (KS_W'(dr) < eff_k) begin
                col_sum = col_sum + COL_SUM_W'(colv[dr]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage B: chain of window column cells
    // ------------------------------------------------------------------
    logic [COL_SUM_W-1:0] col_link [NK+1];
    logic [WIN_SUM_W-1:0] acc_link [NK+1];

    assign col_link[0] = col_sum;
    assign acc_link[0] = '0;

    for (genvar j = 0; j < NK; j++) begin : g_cell
        wvb_cell u_cell (
            .aclk     (aclk),
            .shift_en (adv_a),
            .col_in   (col_link[j]),
            .active   (KS_W'(j) < eff_k),
            .acc_in   (acc_link[j]),
            .col_out  (col_link[j+1]),
            .acc_out  (acc_link[j+1])
        );
    end

    always_ff @(posedge aclk) begin
        if (adv_a) begin
            tag_b_reg <= tag_a_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage C: registered window sum
    // ------------------------------------------------------------------
    logic [WIN_SUM_W-1:0] sum_c_reg;
    logic [THR_W-1:0]     thresh;

    always_ff @(posedge aclk) begin
        if (adv_b) begin
            sum_c_reg <= acc_link[NK];
            tag_c_reg <= tag_b_reg;
        end
    end

    assign thresh = THR_W'(fg_reg) * THR_W'(VOTE_FACTOR);

    // ------------------------------------------------------------------
    // Output register: threshold vote
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (adv_c && tag_c_reg.emit) begin
            m_pixel_out  <= (sum_c_reg >= WIN_SUM_W'(thresh)) ? fg_reg : '0;
            m_center_row <= tag_c_reg.center_row;
            m_center_col <= tag_c_reg.center_col;
            m_frame_end  <= tag_c_reg.frame_end;
        end
    end

    assign m_valid = m_valid_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // The bank slot stays inside the bank count.
    a_slot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, slot_reg} < (SW+1)'(MAX_KERNEL))
        else $error("line memory slot out of range");

    // The first row of a frame always writes the first bank.
    a_slot_row0: assert property (@(posedge aclk) disable iff (!aresetn)
        (row_reg == '0) |-> (slot_reg == '0))
        else $error("slot out of step with row counter");

    // Input back-pressure only when every stage holds a request.
    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (va_reg && vb_reg && vc_reg && m_valid_reg))
        else $error("input stalled while the pipeline has a free stage");

endmodule

`default_nettype wire

// ===== hw/rtl/wvb_ram.sv =====
// Generic simple dual-port RAM with a registered read port.
`default_nettype none

module wvb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Read port; the output holds while no read is enabled.
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/wvb_cell.sv =====
// One window column cell: holds a column sum, shifts it on and adds it into the window sum.
`default_nettype none

module wvb_cell import wvb_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 shift_en,
    input  wire logic [COL_SUM_W-1:0] col_in,
    input  wire logic                 active,
    input  wire logic [WIN_SUM_W-1:0] acc_in,
    output logic      [COL_SUM_W-1:0] col_out,
    output logic      [WIN_SUM_W-1:0] acc_out
);

    logic [COL_SUM_W-1:0] col_reg;

    // Take the neighbour's column whenever a new pixel enters the window.
    always_ff @(posedge aclk) begin
        if (shift_en) begin
            col_reg <= col_in;
        end
    end

    // Only the columns inside the current kernel count towards the sum.
    assign acc_out = acc_in + (active ? WIN_SUM_W'(col_reg) : '0);
    assign col_out = col_reg;

endmodule

`default_nettype wire

// ===== dv/vote_filter_checker.sv =====
// Result checker of the window vote binarise filter: watches both channels and the register port.
`timescale 1ns / 100ps

module vote_filter_checker import wvb_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // Register port, watched for writes
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [APB_AW-1:0]    paddr,
    input  wire logic [APB_DW-1:0]    pwdata,
    input  wire logic                 pready,
    // Pixel channel
    input  wire logic                 s_valid,
    input  wire logic                 s_ready,
    input  wire logic [PIX_W-1:0]     s_pixel_in,
    // Result channel
    input  wire logic                 m_valid,
    input  wire logic                 m_ready,
    input  wire logic [PIX_W-1:0]     m_pixel_out,
    input  wire logic [ROW_W-1:0]     m_center_row,
    input  wire logic [COL_OUT_W-1:0] m_center_col,
    input  wire logic                 m_frame_end,
    // Number of results still awaited, and the number of mismatches so far
    output int                        votes_pending,
    output int                        mismatch_total
);

    localparam int LINE_ROWS = 7;
    localparam int LINE_COLS = 1024;

    typedef struct {
        logic [PIX_W-1:0]     level;
        logic [ROW_W-1:0]     row;
        logic [COL_OUT_W-1:0] col;
        logic                 last;
    } vote_t;

    // Shadow copy of the registers.
    logic [FW_W-1:0]  width_reg;
    logic [FH_W-1:0]  height_reg;
    logic [KS_W-1:0]  kernel_reg;
    logic [PIX_W-1:0] fg_reg;

    // Predicted line store and frame position of the next pixel.
    logic [PIX_W-1:0] line_mem [LINE_ROWS][LINE_COLS];
    int               next_row;
    int               next_col;

    vote_t            expected_votes[$];
    int               mismatches;

    // Sizes of 0 count as 1, and sizes above the line length count as the line length.
    function automatic int frame_span(input logic [10:0] raw);
        if (raw == 0) return 1;
        if (raw > 1024) return 1024;
        return int'(raw);
    endfunction

    // Stores one pixel and, when it completes a window, queues the vote of that window.
    task automatic take_pixel(input logic [PIX_W-1:0] pix);
        int    w;
        int    h;
        int    k;
        int    rad;
        int    window_total;
        int    dr;
        int    dc;
        vote_t v;
        w   = frame_span(width_reg);
        h   = frame_span(height_reg);
        k   = int'(kernel_reg | 3'd1);
        rad = k / 2;
        line_mem[next_row % LINE_ROWS][next_col] = pix;
        if (next_row < h && next_col < w && next_row >= 2 * rad && next_col >= 2 * rad) begin
            window_total = 0;
            for (dr = 0; dr < k; dr++) begin
                for (dc = 0; dc < k; dc++) begin
                    window_total += line_mem[(next_row - dr) % LINE_ROWS][next_col - dc];
                end
            end
            v.level = (window_total >= VOTE_FACTOR * int'(fg_reg)) ? fg_reg : '0;
            v.row   = ROW_W'(next_row - rad);
            v.col   = COL_OUT_W'(next_col - rad);
            v.last  = (next_row == h - 1) && (next_col == w - 1);
            expected_votes.push_back(v);
        end
        // Advance the position; one beyond the frame wraps at its next advance.
        next_col++;
        if (next_col >= w) begin
            next_col = 0;
            next_row++;
            if (next_row >= h) begin
                next_row = 0;
            end
        end
    endtask

    always @(posedge aclk) begin : watch
        vote_t want;
        int    r;
        int    c;
        if (!aresetn) begin
            width_reg  = 11'd960;
            height_reg = 11'd540;
            kernel_reg = 3'd3;
            fg_reg     = 8'd255;
            next_row   = 0;
            next_col   = 0;
            mismatches = 0;
            expected_votes.delete();
            for (r = 0; r < LINE_ROWS; r++) begin
                for (c = 0; c < LINE_COLS; c++) begin
                    line_mem[r][c] = '0;
                end
            end
        end else begin
            // Register writes complete on the access cycle.
            if (psel && penable && pwrite && pready) begin
                case (wvb_reg_idx_t'(paddr[3:2]))
                    REG_FRAME_WIDTH:  width_reg  = pwdata[FW_W-1:0];
                    REG_FRAME_HEIGHT: height_reg = pwdata[FH_W-1:0];
                    REG_KERNEL_SIZE:  kernel_reg = pwdata[KS_W-1:0];
                    REG_FG_VALUE:     fg_reg     = pwdata[PIX_W-1:0];
                    default: ;
                endcase
            end

            // Check a result request before queueing anything for this edge's pixel.
            if (m_valid && m_ready) begin
                if (expected_votes.size() == 0) begin
                    $error("result at row %0d col %0d with none expected",
                           m_center_row, m_center_col);
                    mismatches++;
                end else begin
                    want = expected_votes.pop_front();
                    if (m_pixel_out !== want.level) begin
                        $error("pixel_out: expected %0d, got %0d", want.level, m_pixel_out);
                        mismatches++;
                    end
                    if (m_center_row !== want.row) begin
                        $error("center_row: expected %0d, got %0d", want.row, m_center_row);
                        mismatches++;
                    end
                    if (m_center_col !== want.col) begin
                        $error("center_col: expected %0d, got %0d", want.col, m_center_col);
                        mismatches++;
                    end
                    if (m_frame_end !== want.last) begin
                        $error("frame_end: expected %0d, got %0d", want.last, m_frame_end);
                        mismatches++;
                    end
                end
            end

            // Pixel request accepted at this edge.
            if (s_valid && s_ready) begin
                take_pixel(s_pixel_in);
            end
        end
        votes_pending  <= expected_votes.size();
        mismatch_total <= mismatches;
    end

endmodule

// ===== dv/tb_window_vote_binarize_filter.sv =====
// Test bench top of the window vote binarise filter: pixel stimulus, register writes and verdict.
`timescale 1ns / 100ps

module tb_window_vote_binarize_filter;
    import wvb_pkg::*;

    localparam int RANDOM_ITEMS = 2000;
    localparam int DRAIN_CYCLES = 12;
    localparam int HOLD_CYCLES  = 150;

    logic                 aclk         = 1'b0;
    logic                 aresetn      = 1'b0;
    logic                 psel         = 1'b0;
    logic                 penable      = 1'b0;
    logic                 pwrite       = 1'b0;
    logic [APB_AW-1:0]    paddr        = '0;
    logic [APB_DW-1:0]    pwdata       = '0;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;
    logic                 s_valid      = 1'b0;
    logic                 s_ready;
    logic [PIX_W-1:0]     s_pixel_in   = '0;
    logic                 m_valid;
    logic                 m_ready      = 1'b0;
    logic [PIX_W-1:0]     m_pixel_out;
    logic [ROW_W-1:0]     m_center_row;
    logic [COL_OUT_W-1:0] m_center_col;
    logic                 m_frame_end;

    int                   votes_pending;
    int                   mismatch_total;

    // Register values as written, and the frame position of the next pixel.
    logic [FW_W-1:0]      width_raw  = 11'd960;
    logic [FH_W-1:0]      height_raw = 11'd540;
    logic [KS_W-1:0]      ks_raw     = 3'd3;
    logic [PIX_W-1:0]     fg_raw     = 8'd255;
    int                   pos_row    = 0;
    int                   pos_col    = 0;
    int                   items_sent = 0;
    int                   level_style = 0;
    bit                   tx_idle    = 1'b1;

    always #6 aclk = ~aclk;

    window_vote_binarize_filter dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_pixel_in   (s_pixel_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_pixel_out  (m_pixel_out),
        .m_center_row (m_center_row),
        .m_center_col (m_center_col),
        .m_frame_end  (m_frame_end)
    );

    vote_filter_checker u_vote_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_pixel_in     (s_pixel_in),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_pixel_out    (m_pixel_out),
        .m_center_row   (m_center_row),
        .m_center_col   (m_center_col),
        .m_frame_end    (m_frame_end),
        .votes_pending  (votes_pending),
        .mismatch_total (mismatch_total)
    );

    function automatic int frame_span(input logic [10:0] raw);
        if (raw == 0) return 1;
        if (raw > 1024) return 1024;
        return int'(raw);
    endfunction

    // Pixel levels: either a binary picture, levels scaled around the vote threshold,
    // full-range noise, or only the extremes.
    function automatic logic [PIX_W-1:0] pick_level();
        int k;
        int lim;
        k   = int'(ks_raw | 3'd1);
        lim = (10 * int'(fg_raw)) / (k * k);
        if (lim > 255) lim = 255;
        case (level_style)
            0:       return ($urandom_range(0, 1) != 0) ? fg_raw : 8'd0;
            1:       return PIX_W'($urandom_range(0, lim));
            2:       return PIX_W'($urandom_range(0, 255));
            default: return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
        endcase
    endfunction

    // One register write: setup cycle, then access cycle.
    task automatic write_reg(input wvb_reg_idx_t idx, input int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'({idx, 2'b00});
        pwdata  <= APB_DW'(value);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_FRAME_WIDTH:  width_raw  = FW_W'(value);
            REG_FRAME_HEIGHT: height_raw = FH_W'(value);
            REG_KERNEL_SIZE:  ks_raw     = KS_W'(value);
            REG_FG_VALUE:     fg_raw     = PIX_W'(value);
            default: ;
        endcase
    endtask

    task automatic set_frame(input int w, input int h, input int k, input int fg);
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
        write_reg(REG_KERNEL_SIZE, k);
        write_reg(REG_FG_VALUE, fg);
    endtask

    // Offers one pixel request, after a random gap while tx_idle is set, and waits until it is taken.
    task automatic send_pixel(input logic [PIX_W-1:0] pix);
        int gap;
        gap = tx_idle ? $urandom_range(0, 10) : 0;
        if ($urandom_range(0, 63) == 0) tx_idle = !tx_idle;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_pixel_in <= pix;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        pos_col++;
        if (pos_col >= frame_span(width_raw)) begin
            pos_col = 0;
            pos_row++;
            if (pos_row >= frame_span(height_raw)) pos_row = 0;
        end
    endtask

    // Sends pixels until the position is back at the start of a frame.
    task automatic run_to_frame_start();
        do send_pixel(pick_level()); while (pos_row != 0 || pos_col != 0);
    endtask

    // Stops sending and waits until every expected result has left the block.
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (votes_pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Result side: random stalls, stretches without stalls, and two long hold-offs.
    initial begin : result_sink
        int  gap;
        int  results_taken;
        bit  rx_idle;
        results_taken = 0;
        rx_idle       = 1'b1;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            gap = rx_idle ? $urandom_range(0, 10) : 0;
            if (results_taken == 60 || results_taken == 1200) gap = HOLD_CYCLES;
            if ($urandom_range(0, 63) == 0) rx_idle = !rx_idle;
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            results_taken++;
        end
    end

    initial begin : stimulus
        int rand_start;
        int frames;
        int pick;
        int w;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Smallest frame with a window of one: each pixel is its own window.
        set_frame(0, 0, 0, 51);
        send_pixel(8'd255);
        send_pixel(8'd254);
        send_pixel(8'd0);
        settle();

        // Even kernel raised to three, one full window of maximum pixels.
        set_frame(3, 3, 2, 255);
        repeat (9) send_pixel(8'd255);
        settle();

        // Frame smaller than the window gives nothing.
        set_frame(2, 2, 3, 255);
        repeat (4) send_pixel(8'd255);
        settle();

        // Full-width frame with the largest window; also fills the whole line store.
        level_style = 1;
        set_frame(2047, 7, 6, $urandom_range(0, 255));
        run_to_frame_start();
        settle();

        // Tallest frame, one column wide, foreground zero.
        level_style = 2;
        set_frame(0, 2047, 0, 0);
        run_to_frame_start();
        settle();

        // Configuration changed part-way through a frame.
        level_style = 0;
        set_frame(10, 9, 3, 40);
        repeat (45) send_pixel(pick_level());
        settle();
        write_reg(REG_KERNEL_SIZE, 5);
        repeat (12) send_pixel(pick_level());
        settle();
        write_reg(REG_FRAME_WIDTH, 4);
        repeat (10) send_pixel(pick_level());
        settle();
        write_reg(REG_FRAME_WIDTH, 16);
        repeat (10) send_pixel(pick_level());
        settle();
        write_reg(REG_FRAME_HEIGHT, 5);
        run_to_frame_start();
        settle();

        // Random frames under random settings.
        rand_start = items_sent;
        while (items_sent - rand_start < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) w = 0;
            else if (pick == 1) w = $urandom_range(1025, 2047);
            else if (pick == 2) w = $urandom_range(100, 1024);
            else w = $urandom_range(1, 20);
            write_reg(REG_FRAME_WIDTH, w);
            if (frame_span(FW_W'(w)) > 64) begin
                write_reg(REG_FRAME_HEIGHT, $urandom_range(1, 3));
                frames = 1;
            end else begin
                write_reg(REG_FRAME_HEIGHT,
                          ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 14));
                frames = $urandom_range(1, 3);
            end
            write_reg(REG_KERNEL_SIZE, $urandom_range(0, 7));
            pick = $urandom_range(0, 9);
            write_reg(REG_FG_VALUE, (pick == 0) ? 0 : (pick == 1) ? 255 : $urandom_range(0, 255));
            level_style = $urandom_range(0, 3);
            tx_idle     = ($urandom_range(0, 3) != 0);

            repeat (frames) run_to_frame_start();

            // Now and then a register changes mid-frame.
            if ($urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(1, 30)) send_pixel(pick_level());
                settle();
                case ($urandom_range(0, 3))
                    0:       write_reg(REG_FRAME_WIDTH, $urandom_range(1, 20));
                    1:       write_reg(REG_FRAME_HEIGHT, $urandom_range(1, 14));
                    2:       write_reg(REG_KERNEL_SIZE, $urandom_range(0, 7));
                    default: write_reg(REG_FG_VALUE, $urandom_range(0, 255));
                endcase
                run_to_frame_start();
            end
            settle();
        end

        if (mismatch_total == 0) begin
            $display("tb_window_vote_binarize_filter passed");
        end else begin
            $display("tb_window_vote_binarize_filter failed");
        end
        $finish;
    end

    // Hard limit on the run time.
    initial begin : run_limit
        #12_000_000;
        $display("tb_window_vote_binarize_filter failed");
        $finish;
    end

endmodule
